// ===== design/pgmm_pkg.sv =====
// Shared constants, types and command/status structs for the genotype matrix multiply.
`timescale 1ns / 1ps

package pgmm_pkg;

  // Sizing
  localparam int MAX_SUBJECTS = 4096;
  localparam int MAX_COLUMNS  = 8;

  localparam int ROW_W = $clog2(MAX_SUBJECTS);
  localparam int CNT_W = ROW_W + 1;
  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  // Port field widths
  localparam int OPCODE_W     = 2;
  localparam int GBYTE_W      = 8;
  localparam int COL_IDX_W    = 3;
  localparam int WEIGHT_W     = 32;
  localparam int SUBJ_IDX_W   = 12;
  localparam int ACC_W        = 48;
  localparam int SUBJ_CFG_W   = 13;
  localparam int COLS_CFG_W   = 4;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam int LANE_W = ACC_W + 1;              // {sat mark, accumulator}
  localparam int SUM_W  = ACC_W + 1;              // one guard bit for overflow
  localparam int CMP_W  = (CNT_W > SUBJ_CFG_W) ? CNT_W : SUBJ_CFG_W;

  localparam int PAIRS_PER_BYTE = GBYTE_W / 2;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WEIGHT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_GENO   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd3;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUBJECTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS  = 1'b1;

  localparam logic [SUBJ_CFG_W-1:0] NUM_SUBJECTS_RST = 13'd4096;
  localparam logic [COLS_CFG_W-1:0] NUM_COLUMNS_RST  = 4'd8;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic [MAX_COLUMNS-1:0][LANE_W-1:0] acc_row_t;

  typedef struct packed {
    logic       capture;      // latch item fields for a genotype or read transaction
    logic       load_weight;
    logic       clr_step;     // write one zero row of the clear sweep
    logic       geno_step;    // process one bit pair
    logic [1:0] pair;
    logic       geno_end;     // byte done, apply variant end
    logic       rd_issue;
    logic       rd_load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic wb_pending;
  } dp_sts_t;

endpackage

// ===== design/packed_genotype_matrix_multiply.sv =====
// Top level: packed genotype by weight matrix multiply, controller plus datapath.
`timescale 1ns / 1ps
// Genotype byte: 4 bit pairs, then a drain state that overlaps the next acceptance;
//   each subject is one accumulator-row read-modify-write. Weight load: on acceptance.
// Read: row read in ST_READ, output register loaded in ST_RESP once free, held until
//   taken. Clear: a sweep over the accumulator rows, in_ready low throughout.
// Reset (synchronous, active high) restores config defaults and starts the same sweep.

module packed_genotype_matrix_multiply (
  input  logic                                  clk,
  input  logic                                  rst,
  // item channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [pgmm_pkg::OPCODE_W-1:0]         opcode,
  input  logic [pgmm_pkg::GBYTE_W-1:0]          genotype_byte,
  input  logic                                  variant_end,
  input  logic [pgmm_pkg::COL_IDX_W-1:0]        column_index,
  input  logic signed [pgmm_pkg::WEIGHT_W-1:0]  weight_value,
  input  logic [pgmm_pkg::SUBJ_IDX_W-1:0]       subject_index,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pgmm_pkg::ACC_W-1:0]     sum_value,
  output logic                                  saturated_flag,
  // config write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pgmm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pgmm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pgmm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Config registers take a write in any cycle
  assign cfg_ready = 1'b1;

  pgmm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .sts      (sts),
    .cmd      (cmd)
  );

  pgmm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .genotype_byte  (genotype_byte),
    .variant_end    (variant_end),
    .column_index   (column_index),
    .weight_value   (weight_value),
    .subject_index  (subject_index),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sum_value      (sum_value),
    .saturated_flag (saturated_flag)
  );

  // Reset always leads into the clear sweep, so no transaction is taken right after it
  a_reset_sweep: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("transaction accepted right after reset");

  // Single memory write port: sweep and bit-pair write-back never collide
  a_write_port: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_step && sts.wb_pending))
    else $error("clear sweep and write-back in the same cycle");

  // A result appears only from a read transaction
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.rd_load_out))
    else $error("result without a read");

endmodule

// ===== design/pgmm_ctrl.sv =====
// Controller state machine: sequences clear sweeps, bit pairs and accumulator reads.
`timescale 1ns / 1ps

module pgmm_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pgmm_pkg::OPCODE_W-1:0] opcode,
  input  pgmm_pkg::dp_sts_t             sts,
  output pgmm_pkg::dp_cmd_t             cmd
);
  import pgmm_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_GENO  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  localparam logic [1:0] LAST_PAIR = 2'(PAIRS_PER_BYTE - 1);

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] pair;
  logic [1:0] pair_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    pair_next  = pair;
    unique case (state) inside
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE, ST_DRAIN: begin
        // last bit pair writes back during drain; next transaction may enter
        in_ready     = 1'b1;
        cmd.geno_end = (state == ST_DRAIN);
        state_next   = ST_IDLE;
        if (in_valid) begin
          unique case (opcode)
            OP_CLEAR: state_next = ST_CLEAR;
            OP_WEIGHT: cmd.load_weight = 1'b1;
            OP_GENO: begin
              cmd.capture = 1'b1;
              pair_next   = '0;
              state_next  = ST_GENO;
            end
            OP_READ: begin
              cmd.capture = 1'b1;
              state_next  = ST_READ;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_GENO: begin
        cmd.geno_step = 1'b1;
        cmd.pair      = pair;
        pair_next     = pair + 2'd1;
        if (pair == LAST_PAIR) begin
          state_next = ST_DRAIN;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.rd_load_out = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      pair  <= '0;
    end else begin
      state <= state_next;
      pair  <= pair_next;
    end
  end

endmodule

// ===== design/pgmm_datapath.sv =====
// Datapath: config and weight registers, accumulator row memory, saturating lanes, output register.
`timescale 1ns / 1ps

module pgmm_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  pgmm_pkg::dp_cmd_t               cmd,
  output pgmm_pkg::dp_sts_t               sts,
  input  logic [pgmm_pkg::GBYTE_W-1:0]    genotype_byte,
  input  logic                            variant_end,
  input  logic [pgmm_pkg::COL_IDX_W-1:0]  column_index,
  input  logic signed [pgmm_pkg::WEIGHT_W-1:0] weight_value,
  input  logic [pgmm_pkg::SUBJ_IDX_W-1:0] subject_index,
  input  logic                            cfg_valid,
  input  logic [pgmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgmm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [pgmm_pkg::ACC_W-1:0] sum_value,
  output logic                            saturated_flag
);
  import pgmm_pkg::*;

  // Config registers
  logic [SUBJ_CFG_W-1:0] num_subjects;
  logic [COLS_CFG_W-1:0] num_columns;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_subjects <= NUM_SUBJECTS_RST;
      num_columns  <= NUM_COLUMNS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_SUBJECTS: num_subjects <= cfg_data;
        CFG_NUM_COLUMNS:  num_columns  <= cfg_data[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Weights, undefined until loaded
  logic signed [WEIGHT_W-1:0] weights [MAX_COLUMNS];
  logic                       wcol_ok;
  logic [COL_W-1:0]           wcol;

  assign wcol_ok = 32'(column_index) < 32'(MAX_COLUMNS);
  assign wcol    = COL_W'(32'(column_index));

  always_ff @(posedge clk) begin
    if (cmd.load_weight && wcol_ok) begin
      weights[wcol] <= weight_value;
    end
  end

  // Captured item fields
  logic [GBYTE_W-1:0] gbyte_q;
  logic               vend_q;
  logic [ROW_W-1:0]   rd_row_q;
  logic [COL_W-1:0]   rd_col_q;
  logic               rd_ok_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gbyte_q  <= genotype_byte;
      vend_q   <= variant_end;
      rd_row_q <= ROW_W'(32'(subject_index));
      rd_col_q <= wcol;
      rd_ok_q  <= wcol_ok && (32'(subject_index) < 32'(MAX_SUBJECTS));
    end
  end

  // Subject counter
  logic [CNT_W-1:0] counter;
  logic [CMP_W-1:0] ns_ext;
  logic [CMP_W-1:0] limit;
  logic             active;
  logic [GBYTE_W-1:0] gshift;
  logic [1:0]       cur_code;

  assign ns_ext   = CMP_W'(num_subjects);
  assign limit    = (ns_ext > CMP_W'(MAX_SUBJECTS)) ? CMP_W'(MAX_SUBJECTS) : ns_ext;
  assign active   = CMP_W'(counter) < limit;
  assign gshift   = gbyte_q >> {cmd.pair, 1'b0};
  assign cur_code = gshift[1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (cmd.geno_end && vend_q) begin
      counter <= '0;
    end else if (cmd.geno_step && active) begin
      counter <= counter + 1'b1;
    end
  end

  // Write-back pipeline stage
  logic             wb_valid;
  logic [ROW_W-1:0] wb_row;
  logic [1:0]       wb_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= cmd.geno_step && active;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.geno_step) begin
      wb_row  <= counter[ROW_W-1:0];
      wb_code <= cur_code;
    end
  end

  // Clear sweep row counter
  logic [ROW_W-1:0] clr_row;
  logic             clr_last;

  assign clr_last = clr_row == ROW_W'(MAX_SUBJECTS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (cmd.clr_step) begin
      clr_row <= clr_last ? '0 : clr_row + 1'b1;
    end
  end

  // Accumulator row memory
  acc_row_t         mem [MAX_SUBJECTS];
  acc_row_t         rdata;
  acc_row_t         new_row;
  acc_row_t         wr_data;
  logic             rd_en;
  logic [ROW_W-1:0] rd_addr;
  logic             wr_en;
  logic [ROW_W-1:0] wr_addr;

  assign rd_en   = (cmd.geno_step && active) || cmd.rd_issue;
  assign rd_addr = cmd.rd_issue ? rd_row_q : counter[ROW_W-1:0];
  assign wr_en   = cmd.clr_step || wb_valid;
  assign wr_addr = cmd.clr_step ? clr_row : wb_row;
  assign wr_data = cmd.clr_step ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Saturating lanes: dosage 1 adds the weight, dosage 2 adds it doubled
  always_comb begin
    logic [LANE_W-1:0]       lane;
    logic [ACC_W-1:0]        acc;
    logic signed [SUM_W-1:0] amt;
    logic signed [SUM_W-1:0] sum;
    logic                    in_use;
    for (int k = 0; k < MAX_COLUMNS; k++) begin
      lane   = rdata[k];
      acc    = lane[ACC_W-1:0];
      amt    = {{(SUM_W-WEIGHT_W){weights[k][WEIGHT_W-1]}}, weights[k]};
      if (!wb_code[1]) begin
        amt = amt <<< 1;
      end
      sum    = {acc[ACC_W-1], acc} + amt;
      in_use = (k < int'(num_columns)) && !wb_code[0];
      new_row[k] = lane;
      if (in_use) begin
        if (sum[SUM_W-1] != sum[SUM_W-2]) begin
          new_row[k] = {1'b1, sum[SUM_W-1] ? ACC_MIN : ACC_MAX};
        end else begin
          new_row[k] = {lane[ACC_W], sum[ACC_W-1:0]};
        end
      end
    end
  end

  // Output register
  logic [LANE_W-1:0] rd_lane;
  assign rd_lane = rdata[rd_col_q];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rd_load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_load_out) begin
      sum_value      <= rd_ok_q ? rd_lane[ACC_W-1:0] : '0;
      saturated_flag <= rd_ok_q ? rd_lane[ACC_W] : 1'b0;
    end
  end

  assign sts.clr_last   = clr_last;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.wb_pending = wb_valid;

endmodule
